### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ray generator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, switched off while reset is high.
`define CRDG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds through reset.
`define CRDG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/crdg_pkg.sv
// ----------------------------------------------------------------------------
// Camera ray generator package
// Constants, payload types, register codes and coefficient helpers.
// ----------------------------------------------------------------------------
package crdg_pkg;

   localparam int MAX_DIM   = 4096;
   localparam int COEF_BITS = 16;
   localparam int FRAC_BITS = 11;
   localparam int DIM_W     = 13;
   localparam int NDC_W     = 29;
   localparam int MAG_W     = 30;
   localparam int LEN_W     = 31;
   localparam int IDX_W     = 24;
   localparam int DIR_W     = 16;
   localparam int SQRT_W    = 62;
   localparam int SQRT_STEPS = 31;
   localparam int QUO_W     = 15;

   typedef enum logic [2:0] {
      REG_PROJ0    = 3'd0,
      REG_PROJ1    = 3'd1,
      REG_PROJ2    = 3'd2,
      REG_PROJ3    = 3'd3,
      REG_VIEW0    = 3'd4,
      REG_VIEW1    = 3'd5,
      REG_VIEW2    = 3'd6,
      REG_VIEWPORT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic signed [DIR_W-1:0] dir_z;
      logic [IDX_W-1:0]        buffer_index;
   } rsp_type;

   typedef struct packed {
      logic signed [NDC_W:0] u;
      logic signed [NDC_W:0] v;
      logic [IDX_W-1:0]      idx;
   } ndc_type;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic                  zero;
      logic [IDX_W-1:0]      idx;
   } vec_type;

   typedef struct packed {
      vec_type           vec;
      logic [SQRT_W-1:0] sum;
   } proj_type;

   typedef struct packed {
      vec_type          vec;
      logic [LEN_W-1:0] len;
   } sqrt_type;

   typedef struct packed {
      logic [2:0][DIR_W-1:0] n;
      logic [IDX_W-1:0]      idx;
   } unit_type;

   function automatic logic signed [COEF_BITS-1:0] coef(input logic [63:0] row,
                                                       input int unsigned pos);
      return row[pos*COEF_BITS +: COEF_BITS];
   endfunction

endpackage

### sv/camera_ray_direction_generator.sv
// ----------------------------------------------------------------------------
// Camera ray direction generator
// Throughput: one item per cycle; every stage advances together and the
// whole pipeline holds while a result waits under rsp_stall.
// Reset clears all stage valid bits and loads identity matrices and a 1x1
// viewport; no clearing pass follows.
// ----------------------------------------------------------------------------
module camera_ray_direction_generator (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  crdg_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output crdg_pkg::rsp_type       rsp_data,
   input  logic                    csr_wr_en,
   input  crdg_pkg::csr_index_type csr_index,
   input  logic [63:0]             csr_wdata
);
   import crdg_pkg::*;

   logic [3:0][63:0] proj_ff;
   logic [2:0][47:0] view_ff;
   logic [28:0]      vp_ff;

   logic [DIM_W-1:0] width_w, height_w;
   logic             en;

   logic     ndc_valid, proj_valid, sqrt_valid, unit_valid;
   ndc_type  ndc_data;
   proj_type proj_data;
   sqrt_type sqrt_data;
   unit_type unit_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         proj_ff[0] <= 64'd2048;
         proj_ff[1] <= 64'd2048 << 16;
         proj_ff[2] <= 64'd2048 << 32;
         proj_ff[3] <= 64'd2048 << 48;
         view_ff[0] <= 48'd2048;
         view_ff[1] <= 48'd2048 << 16;
         view_ff[2] <= 48'd2048 << 32;
         vp_ff      <= 29'd65537;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_PROJ0:    proj_ff[0] <= csr_wdata;
            REG_PROJ1:    proj_ff[1] <= csr_wdata;
            REG_PROJ2:    proj_ff[2] <= csr_wdata;
            REG_PROJ3:    proj_ff[3] <= csr_wdata;
            REG_VIEW0:    view_ff[0] <= csr_wdata[47:0];
            REG_VIEW1:    view_ff[1] <= csr_wdata[47:0];
            REG_VIEW2:    view_ff[2] <= csr_wdata[47:0];
            REG_VIEWPORT: vp_ff      <= csr_wdata[28:0];
            default:      vp_ff      <= vp_ff;
         endcase
      end
   end

   always_comb begin
      if (vp_ff[15:0] == '0) begin
         width_w = DIM_W'(1);
      end else if (vp_ff[15:0] > 16'(MAX_DIM)) begin
         width_w = DIM_W'(MAX_DIM);
      end else begin
         width_w = vp_ff[DIM_W-1:0];
      end
      if (vp_ff[28:16] == '0) begin
         height_w = DIM_W'(1);
      end else if (vp_ff[28:16] > DIM_W'(MAX_DIM)) begin
         height_w = DIM_W'(MAX_DIM);
      end else begin
         height_w = vp_ff[28:16];
      end
   end

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   crdg_ndc u_ndc (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .width     (width_w),
      .height    (height_w),
      .out_valid (ndc_valid),
      .out_data  (ndc_data)
   );

   crdg_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ndc_valid),
      .in_data   (ndc_data),
      .inv_proj  (proj_ff),
      .out_valid (proj_valid),
      .out_data  (proj_data)
   );

   crdg_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (proj_valid),
      .in_data   (proj_data),
      .out_valid (sqrt_valid),
      .out_data  (sqrt_data)
   );

   crdg_unit u_unit (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sqrt_valid),
      .in_data   (sqrt_data),
      .out_valid (unit_valid),
      .out_data  (unit_data)
   );

   crdg_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (unit_valid),
      .in_data   (unit_data),
      .inv_view  (view_ff),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

### sv/crdg_ndc.sv
// ----------------------------------------------------------------------------
// Pixel to device coordinates
// Computes (2p - d) * 2^16 / d for both axes with one quotient bit per stage,
// and the buffer index alongside.
// ----------------------------------------------------------------------------
module crdg_ndc (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  crdg_pkg::req_type          in_data,
   input  logic [crdg_pkg::DIM_W-1:0] width,
   input  logic [crdg_pkg::DIM_W-1:0] height,
   output logic                       out_valid,
   output crdg_pkg::ndc_type          out_data
);
   import crdg_pkg::*;

   logic             vld_ff [0:NDC_W];
   logic [NDC_W-1:0] wu_ff  [0:NDC_W];
   logic [NDC_W-1:0] wv_ff  [0:NDC_W];
   logic [DIM_W-1:0] ru_ff  [0:NDC_W-1];
   logic [DIM_W-1:0] rv_ff  [0:NDC_W-1];
   logic             su_ff  [0:NDC_W];
   logic             sv_ff  [0:NDC_W];
   logic [IDX_W-1:0] idx_ff [0:NDC_W];

   logic [DIM_W-1:0] tx_in, ty_in, dx_in, dy_in;
   logic             sx_in, sy_in;
   logic [IDX_W:0]   idx_full;

   always_comb begin
      tx_in = {in_data.pixel_x, 1'b0};
      ty_in = {in_data.pixel_y, 1'b0};
      if (tx_in >= width) begin
         dx_in = tx_in - width;
         sx_in = 1'b0;
      end else begin
         dx_in = width - tx_in;
         sx_in = 1'b1;
      end
      if (ty_in >= height) begin
         dy_in = ty_in - height;
         sy_in = 1'b0;
      end else begin
         dy_in = height - ty_in;
         sy_in = 1'b1;
      end
      idx_full = (IDX_W+1)'(in_data.pixel_y) * (IDX_W+1)'(width)
               + (IDX_W+1)'(in_data.pixel_x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wu_ff[0]  <= {dx_in, 16'b0};
         wv_ff[0]  <= {dy_in, 16'b0};
         ru_ff[0]  <= '0;
         rv_ff[0]  <= '0;
         su_ff[0]  <= sx_in;
         sv_ff[0]  <= sy_in;
         idx_ff[0] <= idx_full[IDX_W-1:0];
      end
   end

   for (genvar k = 0; k < NDC_W; k++) begin : g_step
      logic [DIM_W:0]   rnu_in, rnv_in;
      logic             qu_in, qv_in;
      logic [DIM_W-1:0] ru_in, rv_in;

      always_comb begin
         rnu_in = {ru_ff[k], wu_ff[k][NDC_W-1]};
         rnv_in = {rv_ff[k], wv_ff[k][NDC_W-1]};
         qu_in  = rnu_in >= {1'b0, width};
         qv_in  = rnv_in >= {1'b0, height};
         ru_in  = qu_in ? DIM_W'(rnu_in - {1'b0, width})  : rnu_in[DIM_W-1:0];
         rv_in  = qv_in ? DIM_W'(rnv_in - {1'b0, height}) : rnv_in[DIM_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            wu_ff[k+1]  <= {wu_ff[k][NDC_W-2:0], qu_in};
            wv_ff[k+1]  <= {wv_ff[k][NDC_W-2:0], qv_in};
            su_ff[k+1]  <= su_ff[k];
            sv_ff[k+1]  <= sv_ff[k];
            idx_ff[k+1] <= idx_ff[k];
         end
      end

      if (k < NDC_W-1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               ru_ff[k+1] <= ru_in;
               rv_ff[k+1] <= rv_in;
            end
         end
      end
   end

   always_comb begin
      out_valid    = vld_ff[NDC_W];
      out_data.u   = su_ff[NDC_W] ? -$signed({1'b0, wu_ff[NDC_W]})
                                  :  $signed({1'b0, wu_ff[NDC_W]});
      out_data.v   = sv_ff[NDC_W] ? -$signed({1'b0, wv_ff[NDC_W]})
                                  :  $signed({1'b0, wv_ff[NDC_W]});
      out_data.idx = idx_ff[NDC_W];
   end

endmodule

### sv/crdg_proj.sv
// ----------------------------------------------------------------------------
// Projection and normalizing shift
// Multiplies by the inverse projection, folds in the sign of w, scales so
// the largest magnitude lies in [2^29, 2^30) and forms the sum of squares.
// ----------------------------------------------------------------------------
module crdg_proj (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  crdg_pkg::ndc_type   in_data,
   input  logic [3:0][63:0]    inv_proj,
   output logic                out_valid,
   output crdg_pkg::proj_type  out_data
);
   import crdg_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;

   logic signed [COEF_BITS-1:0] c_w [4][4];

   logic signed [45:0] pu_ff [4];
   logic signed [45:0] pv_ff [4];
   logic signed [16:0] cz_ff [4];
   logic [IDX_W-1:0]   i1_ff;

   logic signed [47:0] t_ff [4];
   logic [IDX_W-1:0]   i2_ff;

   logic [47:0]        m3_ff [3];
   logic [2:0]         n3_ff;
   logic [IDX_W-1:0]   i3_ff;

   logic [47:0]        m4_ff [3];
   logic [2:0]         n4_ff;
   logic               z4_ff;
   logic [5:0]         p4_ff;
   logic [IDX_W-1:0]   i4_ff;

   vec_type            vec5_in, vec5_ff, vec6_ff, vec7_ff;
   logic [59:0]        sq_ff [3];
   logic [SQRT_W-1:0]  sum_ff;

   logic [47:0]        orm_in;
   logic [5:0]         lead_in;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            c_w[r][c] = coef(inv_proj[r], c);
         end
      end
   end

   always_comb begin
      orm_in  = m3_ff[0] | m3_ff[1] | m3_ff[2];
      lead_in = '0;
      for (int i = 0; i < 48; i++) begin
         if (orm_in[i]) begin
            lead_in = 6'(i);
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (p4_ff >= 6'd29) begin
            vec5_in.mag[c] = MAG_W'(m4_ff[c] >> (p4_ff - 6'd29));
         end else begin
            vec5_in.mag[c] = MAG_W'(m4_ff[c] << (6'd29 - p4_ff));
         end
      end
      vec5_in.neg  = n4_ff;
      vec5_in.zero = z4_ff;
      vec5_in.idx  = i4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++) begin
            pu_ff[r] <= c_w[r][0] * in_data.u;
            pv_ff[r] <= c_w[r][1] * in_data.v;
            cz_ff[r] <= $signed({c_w[r][2][COEF_BITS-1], c_w[r][2]})
                      + $signed({c_w[r][3][COEF_BITS-1], c_w[r][3]});
         end
         i1_ff <= in_data.idx;

         for (int r = 0; r < 4; r++) begin
            t_ff[r] <= $signed({{2{pu_ff[r][45]}}, pu_ff[r]})
                     + $signed({{2{pv_ff[r][45]}}, pv_ff[r]})
                     + $signed({{15{cz_ff[r][16]}}, cz_ff[r], 16'b0});
         end
         i2_ff <= i1_ff;

         for (int c = 0; c < 3; c++) begin
            m3_ff[c] <= t_ff[c][47] ? 48'(-t_ff[c]) : 48'(t_ff[c]);
            n3_ff[c] <= t_ff[c][47] != t_ff[3][47];
         end
         i3_ff <= i2_ff;

         for (int c = 0; c < 3; c++) begin
            m4_ff[c] <= m3_ff[c];
         end
         n4_ff <= n3_ff;
         z4_ff <= orm_in == '0;
         p4_ff <= lead_in;
         i4_ff <= i3_ff;

         vec5_ff <= vec5_in;

         for (int c = 0; c < 3; c++) begin
            sq_ff[c] <= vec5_ff.mag[c] * vec5_ff.mag[c];
         end
         vec6_ff <= vec5_ff;

         sum_ff  <= SQRT_W'(sq_ff[0]) + SQRT_W'(sq_ff[1]) + SQRT_W'(sq_ff[2]);
         vec7_ff <= vec6_ff;
      end
   end

   always_comb begin
      out_valid    = v7_ff;
      out_data.vec = vec7_ff;
      out_data.sum = sum_ff;
   end

endmodule

### sv/crdg_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of the sum of squares, one result bit per stage.
// ----------------------------------------------------------------------------
module crdg_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  crdg_pkg::proj_type  in_data,
   output logic                out_valid,
   output crdg_pkg::sqrt_type  out_data
);
   import crdg_pkg::*;

   logic              vld_w [0:SQRT_STEPS];
   logic [SQRT_W-1:0] n_w   [0:SQRT_STEPS];
   logic [SQRT_W-1:0] r_w   [0:SQRT_STEPS];
   vec_type           vec_w [0:SQRT_STEPS];

   assign vld_w[0] = in_valid;
   assign n_w[0]   = in_data.sum;
   assign r_w[0]   = '0;
   assign vec_w[0] = in_data.vec;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic              vld_ff;
      logic [SQRT_W-1:0] n_ff, r_ff, n_in, r_in, bit_w, trial_w;
      vec_type           vec_ff;

      always_comb begin
         bit_w   = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
         trial_w = r_w[k] + bit_w;
         if (n_w[k] >= trial_w) begin
            n_in = n_w[k] - trial_w;
            r_in = (r_w[k] >> 1) + bit_w;
         end else begin
            n_in = n_w[k];
            r_in = r_w[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff   <= n_in;
            r_ff   <= r_in;
            vec_ff <= vec_w[k];
         end
      end

      assign vld_w[k+1] = vld_ff;
      assign n_w[k+1]   = n_ff;
      assign r_w[k+1]   = r_ff;
      assign vec_w[k+1] = vec_ff;
   end

   always_comb begin
      out_valid    = vld_w[SQRT_STEPS];
      out_data.vec = vec_w[SQRT_STEPS];
      out_data.len = r_w[SQRT_STEPS][LEN_W-1:0];
   end

endmodule

### sv/crdg_unit.sv
// ----------------------------------------------------------------------------
// Unit vector divider
// Rounds mag * 2^14 / len for three lanes, one quotient bit per stage, and
// restores the signs.
// ----------------------------------------------------------------------------
module crdg_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  crdg_pkg::sqrt_type  in_data,
   output logic                out_valid,
   output crdg_pkg::unit_type  out_data
);
   import crdg_pkg::*;

   logic                  vld_ff  [0:QUO_W];
   logic [2:0][LEN_W-1:0] rem_ff  [0:QUO_W-1];
   logic [2:0][QUO_W-1:0] wk_ff   [0:QUO_W];
   logic [LEN_W-1:0]      len_ff  [0:QUO_W-1];
   logic [2:0]            neg_ff  [0:QUO_W];
   logic                  zero_ff [0:QUO_W];
   logic [IDX_W-1:0]      idx_ff  [0:QUO_W];

   logic [2:0][44:0]      num_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         num_in[c] = 45'({in_data.vec.mag[c], 14'b0}) + 45'(in_data.len[LEN_W-1:1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            rem_ff[0][c] <= LEN_W'(num_in[c][44:QUO_W]);
            wk_ff[0][c]  <= num_in[c][QUO_W-1:0];
         end
         len_ff[0]  <= in_data.len;
         neg_ff[0]  <= in_data.vec.neg;
         zero_ff[0] <= in_data.vec.zero;
         idx_ff[0]  <= in_data.vec.idx;
      end
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [2:0][LEN_W:0]   rn_in;
      logic [2:0]            q_in;
      logic [2:0][LEN_W-1:0] rem_in;

      always_comb begin
         for (int c = 0; c < 3; c++) begin
            rn_in[c]  = {rem_ff[k][c], wk_ff[k][c][QUO_W-1]};
            q_in[c]   = rn_in[c] >= {1'b0, len_ff[k]};
            rem_in[c] = q_in[c] ? LEN_W'(rn_in[c] - {1'b0, len_ff[k]})
                                : rn_in[c][LEN_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int c = 0; c < 3; c++) begin
               wk_ff[k+1][c] <= {wk_ff[k][c][QUO_W-2:0], q_in[c]};
            end
            neg_ff[k+1]  <= neg_ff[k];
            zero_ff[k+1] <= zero_ff[k];
            idx_ff[k+1]  <= idx_ff[k];
         end
      end

      if (k < QUO_W-1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= rem_in;
               len_ff[k+1] <= len_ff[k];
            end
         end
      end
   end

   always_comb begin
      out_valid = vld_ff[QUO_W];
      for (int c = 0; c < 3; c++) begin
         if (zero_ff[QUO_W]) begin
            out_data.n[c] = '0;
         end else if (neg_ff[QUO_W][c]) begin
            out_data.n[c] = -{1'b0, wk_ff[QUO_W][c]};
         end else begin
            out_data.n[c] = {1'b0, wk_ff[QUO_W][c]};
         end
      end
      out_data.idx = idx_ff[QUO_W];
   end

endmodule

### sv/crdg_rotate.sv
// ----------------------------------------------------------------------------
// View rotation and output register
// Rotates the unit vector by the inverse view matrix, rounds to Q1.14 and
// saturates. The last stage is the result register.
// ----------------------------------------------------------------------------
module crdg_rotate (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  crdg_pkg::unit_type  in_data,
   input  logic [2:0][47:0]    inv_view,
   output logic                out_valid,
   output crdg_pkg::rsp_type   out_data
);
   import crdg_pkg::*;

   logic               v1_ff, v2_ff;
   logic signed [31:0] prod_ff [3][3];
   logic [IDX_W-1:0]   i1_ff;
   rsp_type            rsp_ff;

   logic signed [33:0]      s_in   [3];
   logic signed [22:0]      d_in   [3];
   logic signed [DIR_W-1:0] sat_in [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s_in[r] = 34'(prod_ff[r][0]) + 34'(prod_ff[r][1]) + 34'(prod_ff[r][2]);
         d_in[r] = 23'((s_in[r] + 34'sd1024) >>> FRAC_BITS);
         if (d_in[r] > 23'sd32767) begin
            sat_in[r] = 16'sh7FFF;
         end else if (d_in[r] < -23'sd32768) begin
            sat_in[r] = -16'sh8000;
         end else begin
            sat_in[r] = d_in[r][DIR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= coef({16'b0, inv_view[r]}, c) * $signed(in_data.n[c]);
            end
         end
         i1_ff <= in_data.idx;

         rsp_ff.dir_x        <= sat_in[0];
         rsp_ff.dir_y        <= sat_in[1];
         rsp_ff.dir_z        <= sat_in[2];
         rsp_ff.buffer_index <= i1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = rsp_ff;

endmodule

### sv/crdg_checker.sv
// ----------------------------------------------------------------------------
// Camera ray generator port checker
// Watches the item channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crdg_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input crdg_pkg::rsp_type rsp_data
);
   import crdg_pkg::*;

   `CRDG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result item dropped while stalled")
   `CRDG_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_data), "stalled result item changed")
   `CRDG_ASSERT(a_backpressure, clock, reset, rsp_valid && rsp_stall |-> req_stall, "input item taken while the pipeline holds")
   `CRDG_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result item shown right after reset")

endmodule

bind camera_ray_direction_generator crdg_checker u_crdg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
